/* hdl/mer_pkg.sv */
package mer_pkg;

    localparam int COORD_BITS_DEF  = 11;
    localparam int RADIUS_BITS_DEF = 10;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam logic [1:0] PT_LAST = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_PRX,
        S_PRY,
        S_UPD1,
        S_UPD2,
        S_UPD3,
        S_HAND
    } state_t;

    typedef struct packed {
        logic load;
        logic mul_sqx;
        logic mul_sqy;
        logic mul_prx;
        logic mul_pry;
        logic snap;
        logic upd1;
        logic upd2;
        logic upd3;
        logic region_two;
    } dp_cmd_t;

    typedef struct packed {
        logic radii_zero;
        logic s0_lt_s1;
        logic s0_gt_s1;
    } dp_stat_t;

endpackage

/* hdl/midpoint_ellipse_rasterizer_top.sv */
// Midpoint ellipse outline rasterizer. An item with s_tuser = 0 starts a new ellipse
// from the center and radii in s_tdata and produces no output; after the accept it
// holds the block for four passes through the shared multiplier for rx^2, ry^2,
// ry^2*rx and rx^2*ry. An item with s_tuser = 1 advances one step and yields four
// mirrored points (+x,+y) (-x,+y) (-x,-y) (+x,-y), one per beat on m_tdata, with
// m_tlast on the fourth point of the final step. In the controller a step passes
// through accept, three term-update states (skipped when both radii are zero) and a
// hand-off to the output stage that waits while the stage is busy; the four output
// beats drain while the next step is updated. Steps while no ellipse is active
// produce nothing.
module midpoint_ellipse_rasterizer_top #(
    parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // center_x, center_y, radius_x, radius_y
    input  logic [((2*COORD_BITS+2*RADIUS_BITS+7)/8)*8-1:0] s_tdata,
    // cmd
    input  logic s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // pixel_x, pixel_y
    output logic [((2*COORD_BITS+4+7)/8)*8-1:0] m_tdata,
    output logic m_tlast
);
    import mer_pkg::*;

    localparam int C        = COORD_BITS;
    localparam int R        = RADIUS_BITS;
    localparam int P        = C + 2;
    localparam int OUT_BITS = ((2*C+4+7)/8)*8;

    dp_cmd_t               cmd;
    dp_stat_t              stat;
    logic                  out_load, out_fin, out_busy;
    logic [C-1:0]          center_x, center_y;
    logic signed [R+1:0]   snap_x, snap_y;
    logic [P-1:0]          pixel_x, pixel_y;

    mer_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_cmd   (s_tuser),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd),
        .out_busy (out_busy),
        .out_load (out_load),
        .out_fin  (out_fin)
    );

    mer_dp #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_dp (
        .aclk        (aclk),
        .cmd         (cmd),
        .stat        (stat),
        .in_center_x (s_tdata[C-1:0]),
        .in_center_y (s_tdata[2*C-1:C]),
        .in_radius_x (s_tdata[2*C+R-1:2*C]),
        .in_radius_y (s_tdata[2*C+2*R-1:2*C+R]),
        .center_x    (center_x),
        .center_y    (center_y),
        .snap_x      (snap_x),
        .snap_y      (snap_y)
    );

    mer_out #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (out_load),
        .fin       (out_fin),
        .center_x  (center_x),
        .center_y  (center_y),
        .snap_x    (snap_x),
        .snap_y    (snap_y),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .last      (m_tlast),
        .busy      (out_busy)
    );

    assign m_tdata = OUT_BITS'({pixel_y, pixel_x});

`ifndef NO_ASSERTIONS
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> !m_tvalid)
        else $error("output stage loaded while still busy");

    a_last_ends_batch: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("output continues after final point");

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == CMD_START)) |=> !s_tready)
        else $error("start item not followed by setup cycles");
`endif

endmodule

/* hdl/mer_ctrl.sv */
module mer_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic              in_cmd,
    output logic              in_ready,
    input  mer_pkg::dp_stat_t stat,
    output mer_pkg::dp_cmd_t  cmd,
    input  logic              out_busy,
    output logic              out_load,
    output logic              out_fin
);
    import mer_pkg::*;

    state_t state_reg, state_next;
    logic   active_reg, active_next;
    logic   region_two_reg, region_two_next;
    logic   fin_reg, fin_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            active_reg     <= 1'b0;
            region_two_reg <= 1'b0;
            fin_reg        <= 1'b0;
        end else begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            region_two_reg <= region_two_next;
            fin_reg        <= fin_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        active_next     = active_reg;
        region_two_next = region_two_reg;
        fin_next        = fin_reg;
        cmd             = '0;
        cmd.region_two  = region_two_reg;
        in_ready        = (state_reg == S_IDLE);
        out_load        = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    if (in_cmd == CMD_START) begin
                        cmd.load        = 1'b1;
                        active_next     = 1'b1;
                        region_two_next = 1'b0;
                        state_next      = S_SQX;
                    end else if (active_reg) begin
                        cmd.snap = 1'b1;
                        if (stat.radii_zero) begin
                            fin_next    = 1'b1;
                            active_next = 1'b0;
                            state_next  = S_HAND;
                        end else begin
                            fin_next   = 1'b0;
                            state_next = S_UPD1;
                        end
                    end
                end
            end
            S_SQX: begin
                cmd.mul_sqx = 1'b1;
                state_next  = S_SQY;
            end
            S_SQY: begin
                cmd.mul_sqy = 1'b1;
                state_next  = S_PRX;
            end
            S_PRX: begin
                cmd.mul_prx = 1'b1;
                state_next  = S_PRY;
            end
            S_PRY: begin
                cmd.mul_pry = 1'b1;
                state_next  = S_IDLE;
            end
            S_UPD1: begin
                cmd.upd1   = 1'b1;
                state_next = S_UPD2;
            end
            S_UPD2: begin
                cmd.upd2   = 1'b1;
                state_next = S_UPD3;
            end
            S_UPD3: begin
                cmd.upd3 = 1'b1;
                if (!region_two_reg) begin
                    if (stat.s0_lt_s1) begin
                        region_two_next = 1'b1;
                    end
                end else if (stat.s0_gt_s1) begin
                    fin_next    = 1'b1;
                    active_next = 1'b0;
                end
                state_next = S_HAND;
            end
            S_HAND: begin
                if (!out_busy) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_fin = fin_reg;

endmodule

/* hdl/mer_dp.sv */
module mer_dp #(
    parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
    input  logic                          aclk,
    input  mer_pkg::dp_cmd_t              cmd,
    output mer_pkg::dp_stat_t             stat,
    input  logic [COORD_BITS-1:0]         in_center_x,
    input  logic [COORD_BITS-1:0]         in_center_y,
    input  logic [RADIUS_BITS-1:0]        in_radius_x,
    input  logic [RADIUS_BITS-1:0]        in_radius_y,
    output logic [COORD_BITS-1:0]         center_x,
    output logic [COORD_BITS-1:0]         center_y,
    output logic signed [RADIUS_BITS+1:0] snap_x,
    output logic signed [RADIUS_BITS+1:0] snap_y
);
    import mer_pkg::*;

    localparam int R   = RADIUS_BITS;
    localparam int SQ  = 2 * R;
    localparam int PB  = 3 * R;
    localparam int T   = 3 * R + 6;
    localparam int OFS = R + 2;
    localparam logic [OFS-1:0] OFS_ONE = OFS'(1);

    logic [COORD_BITS-1:0] cx_reg, cy_reg;
    logic [R-1:0]          rx_reg, ry_reg;
    logic [SQ-1:0]         sqx_reg, sqy_reg;
    logic signed [OFS-1:0] ox_reg, oy_reg, snx_reg, sny_reg;
    logic signed [T-1:0]   e_reg, c0_reg, c1_reg, s0_reg, s1_reg, s1i_reg;

    logic [SQ-1:0]         mul_a;
    logic [R-1:0]          mul_b;
    logic [PB-1:0]         prod;
    logic signed [T-1:0]   prod2, d0, d1, sqx_t, sqy_t, tcoef;
    logic signed [T+1:0]   tst;
    logic                  tpos;

    always_comb begin
        mul_a = {{R{1'b0}}, rx_reg};
        mul_b = rx_reg;
        if (cmd.mul_sqy) begin
            mul_a = {{R{1'b0}}, ry_reg};
            mul_b = ry_reg;
        end else if (cmd.mul_prx) begin
            mul_a = sqy_reg;
            mul_b = rx_reg;
        end else if (cmd.mul_pry) begin
            mul_a = sqx_reg;
            mul_b = ry_reg;
        end
    end

    assign prod  = PB'(mul_a) * PB'(mul_b);
    assign prod2 = $signed({{(T-PB-1){1'b0}}, prod, 1'b0});
    assign d0    = $signed({{(T-SQ-1){1'b0}}, sqx_reg, 1'b0});
    assign d1    = $signed({{(T-SQ-1){1'b0}}, sqy_reg, 1'b0});
    assign sqx_t = $signed({{(T-SQ){1'b0}}, sqx_reg});
    assign sqy_t = $signed({{(T-SQ){1'b0}}, sqy_reg});

    // midpoint decision: 2*e + c > 0
    assign tcoef = cmd.region_two ? c1_reg : c0_reg;
    assign tst   = $signed({e_reg[T-1], e_reg, 1'b0}) + $signed({{2{tcoef[T-1]}}, tcoef});
    assign tpos  = !tst[T+1] && (tst != '0);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cx_reg <= in_center_x;
            cy_reg <= in_center_y;
            rx_reg <= in_radius_x;
            ry_reg <= in_radius_y;
            ox_reg <= $signed({2'b00, in_radius_x});
            oy_reg <= '0;
            e_reg  <= '0;
            s1_reg <= '0;
        end
        if (cmd.mul_sqx) begin
            sqx_reg <= prod[SQ-1:0];
            c1_reg  <= $signed({{(T-SQ){1'b0}}, prod[SQ-1:0]});
        end
        if (cmd.mul_sqy) begin
            sqy_reg <= prod[SQ-1:0];
        end
        if (cmd.mul_prx) begin
            s0_reg <= prod2;
        end
        if (cmd.mul_pry) begin
            s1i_reg <= prod2;
            c0_reg  <= sqy_t - s0_reg;
        end
        if (cmd.snap) begin
            snx_reg <= ox_reg;
            sny_reg <= oy_reg;
        end
        if (cmd.upd1) begin
            if (!cmd.region_two) begin
                oy_reg <= oy_reg + OFS_ONE;
                s1_reg <= s1_reg + d0;
                e_reg  <= e_reg + c1_reg;
                c1_reg <= c1_reg + d0;
            end else begin
                ox_reg <= ox_reg + OFS_ONE;
                s0_reg <= s0_reg + d1;
                e_reg  <= e_reg + c0_reg;
                c0_reg <= c0_reg + d1;
            end
        end
        if (cmd.upd2 && tpos) begin
            if (!cmd.region_two) begin
                ox_reg <= ox_reg - OFS_ONE;
                s0_reg <= s0_reg - d1;
                e_reg  <= e_reg + c0_reg;
                c0_reg <= c0_reg + d1;
            end else begin
                oy_reg <= oy_reg - OFS_ONE;
                s1_reg <= s1_reg - d0;
                e_reg  <= e_reg + c1_reg;
                c1_reg <= c1_reg + d0;
            end
        end
        // region one ends: restart from (0, ry)
        if (cmd.upd3 && !cmd.region_two && (s0_reg < s1_reg)) begin
            ox_reg <= '0;
            oy_reg <= $signed({2'b00, ry_reg});
            c0_reg <= sqy_t;
            c1_reg <= sqx_t - s1i_reg;
            e_reg  <= '0;
            s0_reg <= '0;
            s1_reg <= s1i_reg;
        end
    end

    assign stat.radii_zero = (sqx_reg == '0) && (sqy_reg == '0);
    assign stat.s0_lt_s1   = (s0_reg < s1_reg);
    assign stat.s0_gt_s1   = (s0_reg > s1_reg);

    assign center_x = cx_reg;
    assign center_y = cy_reg;
    assign snap_x   = snx_reg;
    assign snap_y   = sny_reg;

endmodule

/* hdl/mer_out.sv */
module mer_out #(
    parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load,
    input  logic                          fin,
    input  logic [COORD_BITS-1:0]         center_x,
    input  logic [COORD_BITS-1:0]         center_y,
    input  logic signed [RADIUS_BITS+1:0] snap_x,
    input  logic signed [RADIUS_BITS+1:0] snap_y,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [COORD_BITS+1:0]         pixel_x,
    output logic [COORD_BITS+1:0]         pixel_y,
    output logic                          last,
    output logic                          busy
);
    import mer_pkg::*;

    localparam int C = COORD_BITS;
    localparam int R = RADIUS_BITS;
    localparam int P = C + 2;
    localparam int W = ((C > R) ? C : R) + 3;

    logic [W-1:0] cxe, cye, oxe, oye;
    logic [W-1:0] xp_sum, xm_sum, yp_sum, ym_sum;
    logic [P-1:0] xp_reg, xm_reg, yp_reg, ym_reg;
    logic         fin_reg;
    logic         valid_reg;
    logic [1:0]   idx_reg;

    assign cxe    = {{(W-C){1'b0}}, center_x};
    assign cye    = {{(W-C){1'b0}}, center_y};
    assign oxe    = {{(W-R-2){snap_x[R+1]}}, snap_x};
    assign oye    = {{(W-R-2){snap_y[R+1]}}, snap_y};
    assign xp_sum = cxe + oxe;
    assign xm_sum = cxe - oxe;
    assign yp_sum = cye + oye;
    assign ym_sum = cye - oye;

    always_ff @(posedge aclk) begin
        if (load) begin
            xp_reg  <= xp_sum[P-1:0];
            xm_reg  <= xm_sum[P-1:0];
            yp_reg  <= yp_sum[P-1:0];
            ym_reg  <= ym_sum[P-1:0];
            fin_reg <= fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end else if (valid_reg && out_ready) begin
            if (idx_reg == PT_LAST) begin
                valid_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 2'd1;
        end
    end

    // quadrant order: (+x,+y) (-x,+y) (-x,-y) (+x,-y)
    always_comb begin
        case (idx_reg)
            2'd0: begin
                pixel_x = xp_reg;
                pixel_y = yp_reg;
            end
            2'd1: begin
                pixel_x = xm_reg;
                pixel_y = yp_reg;
            end
            2'd2: begin
                pixel_x = xm_reg;
                pixel_y = ym_reg;
            end
            default: begin
                pixel_x = xp_reg;
                pixel_y = ym_reg;
            end
        endcase
    end

    assign out_valid = valid_reg;
    assign last      = fin_reg && (idx_reg == PT_LAST);
    assign busy      = valid_reg;

endmodule

/* dv/midpoint_ellipse_rasterizer_top_test.sv */
`timescale 1ns / 100ps

module midpoint_ellipse_rasterizer_top_test;
    import mer_pkg::*;

    localparam int CB          = COORD_BITS_DEF;
    localparam int RB          = RADIUS_BITS_DEF;
    localparam int PB          = CB + 2;
    localparam int S_W         = ((2*CB + 2*RB + 7) / 8) * 8;
    localparam int M_W         = ((2*CB + 4 + 7) / 8) * 8;
    localparam int RAND_ITEMS  = 300;
    localparam int HOLD_CYCLES = 160;

    typedef logic signed [PB-1:0] pix_t;

    typedef enum logic [1:0] {
        EXP_MODEL,
        EXP_NONE,
        EXP_CENTER
    } check_kind_t;

    typedef struct packed {
        logic        cmd;
        logic [CB-1:0] cx;
        logic [CB-1:0] cy;
        logic [RB-1:0] rx;
        logic [RB-1:0] ry;
        check_kind_t chk;
    } stim_t;

    typedef struct packed {
        pix_t x;
        pix_t y;
        logic last;
    } pixel_t;

    logic           aclk;
    logic           aresetn;
    logic           s_tvalid;
    logic           s_tready;
    logic [S_W-1:0] s_tdata;
    logic           s_tuser;
    logic           m_tvalid;
    logic           m_tready;
    logic [M_W-1:0] m_tdata;
    logic           m_tlast;

    midpoint_ellipse_rasterizer_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // outline tracker state
    bit     el_active;
    bit     el_region2;
    longint el_cx, el_cy, el_rx, el_ry;
    longint el_ox, el_oy;
    longint el_sqx2, el_sqy2;
    longint el_err, el_d0, el_d1, el_s0, el_s1;
    pixel_t step_pts [4];

    pixel_t pixel_q [$];
    stim_t  dir_q [$];
    stim_t  cur_item;

    int n_errors   = 0;
    int n_accepted = 0;
    int n_starts   = 0;
    int n_points   = 0;
    int n_done     = 0;
    int n_live     = 0;
    int burst_left = 0;

    function automatic int advance_outline(input stim_t it);
        longint ox, oy;
        bit fin;
        fin = 1'b0;
        if (it.cmd == CMD_START) begin
            el_cx = longint'(it.cx);
            el_cy = longint'(it.cy);
            el_rx = longint'(it.rx);
            el_ry = longint'(it.ry);
            el_sqx2 = 2 * el_rx * el_rx;
            el_sqy2 = 2 * el_ry * el_ry;
            el_ox = el_rx;
            el_oy = 0;
            el_d0 = el_ry * el_ry * (1 - 2 * el_rx);
            el_d1 = el_rx * el_rx;
            el_err = 0;
            el_s0 = 2 * el_ry * el_ry * el_rx;
            el_s1 = 0;
            el_region2 = 1'b0;
            el_active = 1'b1;
            return 0;
        end
        if (!el_active)
            return 0;
        ox = el_ox;
        oy = el_oy;
        if (el_sqx2 == 0 && el_sqy2 == 0) begin
            el_active = 1'b0;
            fin = 1'b1;
        end else if (!el_region2) begin
            el_oy = oy + 1;
            el_s1 += el_sqx2;
            el_err += el_d1;
            el_d1 += el_sqx2;
            if (2 * el_err + el_d0 > 0) begin
                el_ox -= 1;
                el_s0 -= el_sqy2;
                el_err += el_d0;
                el_d0 += el_sqy2;
            end
            if (el_s0 < el_s1) begin
                el_region2 = 1'b1;
                el_ox = 0;
                el_oy = el_ry;
                el_d0 = el_ry * el_ry;
                el_d1 = el_rx * el_rx * (1 - 2 * el_ry);
                el_err = 0;
                el_s0 = 0;
                el_s1 = 2 * el_rx * el_rx * el_ry;
            end
        end else begin
            el_ox = ox + 1;
            el_s0 += el_sqy2;
            el_err += el_d0;
            el_d0 += el_sqy2;
            if (2 * el_err + el_d1 > 0) begin
                el_oy -= 1;
                el_s1 -= el_sqx2;
                el_err += el_d1;
                el_d1 += el_sqx2;
            end
            if (el_s0 > el_s1) begin
                el_active = 1'b0;
                fin = 1'b1;
            end
        end
        // mirror order: (+x,+y) (-x,+y) (-x,-y) (+x,-y)
        for (int k = 0; k < 4; k++) begin
            step_pts[k].x    = pix_t'(el_cx + ((k == 0 || k == 3) ? ox : -ox));
            step_pts[k].y    = pix_t'(el_cy + ((k < 2) ? oy : -oy));
            step_pts[k].last = fin && (k == 3);
        end
        return 4;
    endfunction

    function automatic stim_t random_item(input logic cmd);
        stim_t it;
        it.cmd = cmd;
        it.cx  = CB'($urandom_range(2**CB - 1));
        it.cy  = CB'($urandom_range(2**CB - 1));
        it.rx  = RB'($urandom_range(2**RB - 1));
        it.ry  = RB'($urandom_range(2**RB - 1));
        it.chk = EXP_MODEL;
        return it;
    endfunction

    task automatic add_row(input logic cmd, input int cx, input int cy, input int rx,
                           input int ry, input check_kind_t chk);
        stim_t it;
        it.cmd = cmd;
        it.cx  = CB'(cx);
        it.cy  = CB'(cy);
        it.rx  = RB'(rx);
        it.ry  = RB'(ry);
        it.chk = chk;
        dir_q.push_back(it);
    endtask

    task automatic offer(input stim_t it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        if (it.cmd == CMD_START || el_active)
            n_live++;
        cur_item = it;
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= S_W'({it.ry, it.rx, it.cy, it.cx});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic hold_until_drained();
        if (pixel_q.size() != 0) begin
            s_tvalid <= 1'b0;
            while (pixel_q.size() != 0) @(negedge aclk);
        end
    endtask

    // handshake monitor: predicts on accepted items, checks accepted points
    always @(posedge aclk) begin
        pixel_t e;
        int n;
        if (aresetn && s_tvalid && s_tready) begin
            n = advance_outline(cur_item);
            n_accepted++;
            if (cur_item.cmd == CMD_START)
                n_starts++;
            case (cur_item.chk)
                EXP_NONE: ;
                EXP_CENTER: begin
                    for (int k = 0; k < 4; k++) begin
                        e.x    = pix_t'(cur_item.cx);
                        e.y    = pix_t'(cur_item.cy);
                        e.last = (k == 3);
                        pixel_q.push_back(e);
                    end
                end
                default: begin
                    for (int k = 0; k < n; k++)
                        pixel_q.push_back(step_pts[k]);
                end
            endcase
        end
        if (aresetn && m_tvalid && m_tready) begin
            n_points++;
            if (m_tlast)
                n_done++;
            if (pixel_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 20)
                    $display("%0t: unexpected point: got x=%0d y=%0d last=%0b", $time,
                             $signed(m_tdata[PB-1:0]), $signed(m_tdata[2*PB-1:PB]), m_tlast);
            end else begin
                e = pixel_q.pop_front();
                if (m_tdata[PB-1:0] !== e.x || m_tdata[2*PB-1:PB] !== e.y
                        || m_tlast !== e.last) begin
                    n_errors++;
                    if (n_errors <= 20)
                        $display("%0t: exp x=%0d y=%0d l=%0b, got x=%0d y=%0d l=%0b",
                                 $time, e.x, e.y, e.last, $signed(m_tdata[PB-1:0]),
                                 $signed(m_tdata[2*PB-1:PB]), m_tlast);
                end
            end
        end
    end

    // receiver: shifting stall pattern plus one long hold-off
    initial begin
        int mode;
        int left;
        bit hold_done;
        mode = 0;
        left = 0;
        hold_done = 1'b0;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (!hold_done && n_accepted >= 80) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            if (left == 0) begin
                mode = $urandom_range(2);
                left = $urandom_range(16, 64);
            end
            left--;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(1) == 1);
                default: m_tready <= ($urandom_range(3) == 0);
            endcase
        end
    end

    initial begin
        stim_t it;
        int n_seq;
        int sel;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = 1'b0;
        s_tdata  = '0;
        cur_item = '0;
        n_seq = 0;

        add_row(CMD_STEP,     0,    0,    0,    0, EXP_NONE);
        add_row(CMD_START, 2047,    0,    0,    0, EXP_NONE);
        add_row(CMD_STEP,  2047,    0,    0,    0, EXP_CENTER);
        add_row(CMD_STEP,  2047,    0,    0,    0, EXP_NONE);
        add_row(CMD_START, 2047, 2047, 1023, 1023, EXP_NONE);
        add_row(CMD_STEP,  2047, 2047, 1023, 1023, EXP_MODEL);
        add_row(CMD_STEP,     0,    0,    0,    0, EXP_MODEL);
        add_row(CMD_STEP,  1365,  682,  341,  682, EXP_MODEL);
        add_row(CMD_START,    0,    0, 1023,    0, EXP_NONE);
        add_row(CMD_STEP,     0,    0,    0,    0, EXP_MODEL);
        add_row(CMD_STEP,     0,    0,    0,    0, EXP_MODEL);
        add_row(CMD_STEP,     0,    0,    0,    0, EXP_NONE);
        add_row(CMD_START,    0, 2047,    0, 1023, EXP_NONE);
        add_row(CMD_STEP,     0, 2047,    0, 1023, EXP_MODEL);
        add_row(CMD_STEP,     0, 2047,    0, 1023, EXP_MODEL);
        add_row(CMD_STEP,     0, 2047,    0, 1023, EXP_NONE);
        add_row(CMD_START, 1000,   24,    3,    2, EXP_NONE);
        for (int i = 0; i < 7; i++)
            add_row(CMD_STEP, 0, 0, 0, 0, EXP_MODEL);

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_q[i])
            offer(dir_q[i]);

        n_live = 0;
        while (n_live < RAND_ITEMS) begin
            if (n_seq % 40 == 0)
                hold_until_drained();
            n_seq++;
            if ($urandom_range(99) < 10) begin
                offer(random_item(1'($urandom_range(1))));
            end else begin
                it = random_item(CMD_START);
                sel = $urandom_range(19);
                case (sel)
                    0: it.rx = '0;
                    1: it.ry = '0;
                    2: ;
                    default: begin
                        it.rx = RB'($urandom_range(12));
                        it.ry = RB'($urandom_range(12));
                    end
                endcase
                offer(it);
                if (sel == 2 || $urandom_range(5) == 0) begin
                    repeat ($urandom_range(1, 6)) offer(random_item(CMD_STEP));
                end else begin
                    while (el_active) offer(random_item(CMD_STEP));
                    repeat ($urandom_range(0, 2)) offer(random_item(CMD_STEP));
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        if (pixel_q.size() != 0)
            n_errors++;

        $display("Sent %0d items incl. %0d ellipse starts; checked %0d outline points,",
                 n_accepted, n_starts, n_points);
        $display("%0d outlines ran to their final point, under random stalls and a long hold.",
                 n_done);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #(2_000_000);
        $display("%0t: timeout, outline points still pending: %0d", $time, pixel_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
